>>> hdl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aes_pkg;

   localparam int AES_ROUNDS = 10;
   localparam int WORD_W     = 64;
   localparam int BLOCK_W    = 128;

   // register indexes of the config port
   localparam logic CSR_KEY_HIGH = 1'b0;
   localparam logic CSR_KEY_LOW  = 1'b1;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [7:0] RCON_FIRST = 8'h01;
   localparam logic [7:0] GF_POLY    = 8'h1b;

   // forward s-box, entry 0 in the top byte
   localparam logic [2047:0] SBOX_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16};

   // inverse s-box
   localparam logic [2047:0] INV_SBOX_BITS = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] v);
      sbox = SBOX_BITS[2047 - 8 * int'(v) -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      inv_sbox = INV_SBOX_BITS[2047 - 8 * int'(v) -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      xtime = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
      get_byte = s[127 - 8 * i -: 8];
   endfunction

   function automatic logic [127:0] fwd_mix(input logic [127:0] s);
      logic [7:0] a [4];
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) a[r] = get_byte(s, r + 4 * c);
         for (int r = 0; r < 4; r++) begin
            o[127 - 8 * (r + 4 * c) -: 8] = xtime(a[r]) ^ xtime(a[(r + 1) % 4])
               ^ a[(r + 1) % 4] ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
         end
      end
      fwd_mix = o;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]  = get_byte(s, r + 4 * c);
            x2[r] = xtime(a[r]);
            x4[r] = xtime(x2[r]);
            x8[r] = xtime(x4[r]);
         end
         // 0e, 0b, 0d, 09 along the row
         for (int r = 0; r < 4; r++) begin
            o[127 - 8 * (r + 4 * c) -: 8] =
                 (x8[r] ^ x4[r] ^ x2[r])
               ^ (x8[(r + 1) % 4] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4])
               ^ (x8[(r + 2) % 4] ^ x4[(r + 2) % 4] ^ a[(r + 2) % 4])
               ^ (x8[(r + 3) % 4] ^ a[(r + 3) % 4]);
         end
      end
      inv_mix = o;
   endfunction

endpackage

`default_nettype wire

>>> hdl/aes_key_exp.sv
`timescale 1ns / 1ps
`default_nettype none

module aes_key_exp
   import aes_pkg::*;
#(
   parameter int ROUNDS = AES_ROUNDS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [WORD_W-1:0]         csr_wdata,
   output logic [ROUNDS:0][BLOCK_W-1:0]   round_keys,
   output logic                           busy
);

   localparam int CNT_W = $clog2(ROUNDS + 1);

   logic [WORD_W-1:0]  key_high_ff, key_high_in;
   logic [WORD_W-1:0]  key_low_ff, key_low_in;
   logic [BLOCK_W-1:0] cur_ff, cur_in;
   logic [7:0]         rc_ff, rc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [BLOCK_W-1:0] rk_ff [1:ROUNDS];
   logic [31:0]        w0, w1, w2, w3, w4, w5, w6, w7, t;

   always_comb begin
      w0 = cur_ff[127:96];
      w1 = cur_ff[95:64];
      w2 = cur_ff[63:32];
      w3 = cur_ff[31:0];
      t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc_ff, 24'h000000};
      w4 = w0 ^ t;
      w5 = w1 ^ w4;
      w6 = w2 ^ w5;
      w7 = w3 ^ w6;
   end

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      cur_in      = cur_ff;
      rc_in       = rc_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      if (csr_we) begin
         if (csr_index == CSR_KEY_HIGH) key_high_in = csr_wdata;
         else key_low_in = csr_wdata;
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            cur_in = {key_high_ff, key_low_ff};
            rc_in  = RCON_FIRST;
            cnt_in = CNT_W'(1);
         end else begin
            cur_in = {w4, w5, w6, w7};
            rc_in  = xtime(rc_ff);
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ROUNDS)) busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         busy_ff     <= 1'b1;
         cnt_ff      <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
      end
      cur_ff <= cur_in;
      rc_ff  <= rc_in;
   end

   // schedule store, one round key per expansion step
   always_ff @(posedge clock) begin
      if (busy_ff && !csr_we && cnt_ff != '0) rk_ff[cnt_ff] <= {w4, w5, w6, w7};
   end

   always_comb begin
      round_keys[0] = {key_high_ff, key_low_ff};
      for (int i = 1; i <= ROUNDS; i++) round_keys[i] = rk_ff[i];
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> hdl/aes_round.sv
`timescale 1ns / 1ps
`default_nettype none

module aes_round
   import aes_pkg::*;
#(
   parameter int ROUNDS = AES_ROUNDS,
   parameter int IDX    = 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               valid_in,
   input  wire logic               cmd_in,
   input  wire logic [BLOCK_W-1:0] state_in,
   input  wire logic [BLOCK_W-1:0] key_enc,
   input  wire logic [BLOCK_W-1:0] key_dec,
   output logic                    valid_out,
   output logic                    cmd_out,
   output logic [BLOCK_W-1:0]      state_out
);

   localparam bit LAST = (IDX == ROUNDS);

   logic               valid_ff;
   logic               cmd_ff;
   logic [BLOCK_W-1:0] state_ff, state_in_nxt;
   logic [BLOCK_W-1:0] enc_sub, enc_shift, enc_mix, dec_shift, dec_sub, dec_ark;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         enc_sub[127 - 8 * i -: 8] = sbox(get_byte(state_in, i));
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            enc_shift[127 - 8 * (r + 4 * c) -: 8] = get_byte(enc_sub, r + 4 * ((c + r) % 4));
            dec_shift[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = get_byte(state_in, r + 4 * c);
         end
      end
      for (int i = 0; i < 16; i++) begin
         dec_sub[127 - 8 * i -: 8] = inv_sbox(get_byte(dec_shift, i));
      end
      enc_mix = LAST ? enc_shift : fwd_mix(enc_shift);
      dec_ark = dec_sub ^ key_dec;
      if (cmd_in == CMD_DECRYPT) state_in_nxt = LAST ? dec_ark : inv_mix(dec_ark);
      else state_in_nxt = enc_mix ^ key_enc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         cmd_ff   <= cmd_in;
         state_ff <= state_in_nxt;
      end
   end

   assign valid_out = valid_ff;
   assign cmd_out   = cmd_ff;
   assign state_out = state_ff;

endmodule

`default_nettype wire

>>> hdl/aes128_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none

// aes-128 cipher and inverse cipher (fips-197 byte order, byte 0 in the top bits of
// the high half). one word enters per cycle while req_stall is low, and passes through
// one register stage for the initial key add and one per round, all stages moving
// together and holding while the result side stalls. the key is written through the csr
// port (index 0 key_high, index 1 key_low); after reset and after every key write the
// round keys are rebuilt by a one-round-per-cycle expander, and req_stall stays high
// until it is done.

module aes128_block_cipher
   import aes_pkg::*;
#(
   parameter int ROUNDS = AES_ROUNDS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // input words
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_cmd,
   input  wire logic [WORD_W-1:0] req_block_high,
   input  wire logic [WORD_W-1:0] req_block_low,
   // result words
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [WORD_W-1:0]      rsp_result_high,
   output logic [WORD_W-1:0]      rsp_result_low,
   // key registers
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [WORD_W-1:0] csr_wdata
);

   logic [ROUNDS:0][BLOCK_W-1:0] round_keys;
   logic                         key_busy;
   logic                         advance;
   logic                         accept;

   // per-stage valid, command and state
   logic [ROUNDS:0]              stg_valid;
   logic [ROUNDS:0]              stg_cmd;
   logic [ROUNDS:0][BLOCK_W-1:0] stg_state;

   logic                         valid0_ff;
   logic                         cmd0_ff;
   logic [BLOCK_W-1:0]           state0_ff;

   aes_key_exp #(
      .ROUNDS (ROUNDS)
   ) u_key (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .round_keys (round_keys),
      .busy       (key_busy)
   );

   // whole pipe moves unless a finished word is held at the output
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance || key_busy;
   assign accept    = req_valid && !req_stall;

   // initial key add: round 0 key for encrypt, last round key for decrypt
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= accept;
      end
      if (advance) begin
         cmd0_ff   <= req_cmd;
         state0_ff <= {req_block_high, req_block_low}
                      ^ ((req_cmd == CMD_DECRYPT) ? round_keys[ROUNDS] : round_keys[0]);
      end
   end

   assign stg_valid[0] = valid0_ff;
   assign stg_cmd[0]   = cmd0_ff;
   assign stg_state[0] = state0_ff;

   for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
      aes_round #(
         .ROUNDS (ROUNDS),
         .IDX    (g)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (stg_valid[g-1]),
         .cmd_in    (stg_cmd[g-1]),
         .state_in  (stg_state[g-1]),
         .key_enc   (round_keys[g]),
         .key_dec   (round_keys[ROUNDS-g]),
         .valid_out (stg_valid[g]),
         .cmd_out   (stg_cmd[g]),
         .state_out (stg_state[g])
      );
   end

   assign rsp_valid       = stg_valid[ROUNDS];
   assign rsp_result_high = stg_state[ROUNDS][127:64];
   assign rsp_result_low  = stg_state[ROUNDS][63:0];

`ifndef SYNTHESIS
   // no word enters while the schedule is being rebuilt
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      key_busy |-> req_stall)
      else $error("word accepted during key expansion");

   // an accepted word shows up in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      accept |=> stg_valid[0])
      else $error("accepted word lost at pipe entry");

   // a held output freezes every stage
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stg_valid))
      else $error("pipe moved while output held");
`endif

endmodule

`default_nettype wire
